### rtl/sfir_pkg.sv
// shared types, widths and coefficient defaults for the symmetric fir
// no dependencies

package sfir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W = 40;
    localparam int NUM_COEF = 8;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    localparam int CFG_IDX_W = 4;

    localparam int TAPS_DEF = 15;
    localparam int SCALE_SHIFT_DEF = 17;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0] t_acc;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OUTER_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = CFG_IDX_W'(NUM_COEF - 1);

    localparam t_coef COEF_RESET [NUM_COEF] = '{
        -16'sd306, 16'sd1, 16'sd1032, 16'sd3430,
        16'sd7961, 16'sd15266, 16'sd23994, 16'sd28309
    };

    localparam t_sample SAT_MAX = 16'sh7fff;
    localparam t_sample SAT_MIN = -16'sh8000;

    // coefficient register shared by tap k and its mirror tap
    function automatic int coef_index(input int k, input int taps);
        int m;
        m = k;
        if (taps - 1 - k < m) m = taps - 1 - k;
        if (m < 0) m = 0;
        if (m > NUM_COEF - 1) m = NUM_COEF - 1;
        return m;
    endfunction

endpackage

### rtl/sfir_tap_cell.sv
// one tap of the delay line: holds a sample, hands it on, forms its product
// depends on sfir_pkg

module sfir_tap_cell
    import sfir_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shift_en,
    input  t_sample i_sample,
    input  t_coef   i_coef,
    output t_sample o_sample,
    output t_prod   o_prod
);

    t_sample r_sample;
    t_prod   r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift_en) begin
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift_en) begin
            r_prod <= i_coef * i_sample;
        end
    end

    assign o_sample = r_sample;
    assign o_prod = r_prod;

endmodule

### rtl/sfir_add_tree.sv
// registered binary adder tree over the tap products
// depends on sfir_pkg

module sfir_add_tree
    import sfir_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_prod i_prod [TAPS],
    output logic  o_valid,
    output t_acc  o_sum
);

    localparam int LEVELS = $clog2(TAPS);
    localparam int LEAVES = 1 << LEVELS;

    t_acc w_leaf [LEAVES];
    t_acc r_node [LEVELS][LEAVES];
    logic [LEVELS-1:0] r_valid;

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < TAPS) begin : g_used
            assign w_leaf[i] = ACC_W'(i_prod[i]);
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
    end

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        for (genvar i = 0; i < (LEAVES >> (l + 1)); i++) begin : g_node
            if (l == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_node[l][i] <= w_leaf[2*i] + w_leaf[2*i+1];
                    end
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_node[l][i] <= r_node[l-1][2*i] + r_node[l-1][2*i+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[LEVELS-2:0], i_valid};
        end
    end

    assign o_valid = r_valid[LEVELS-1];
    assign o_sum = r_node[LEVELS-1][0];

endmodule

### rtl/symmetric_fir_15_tap_q17_top.sv
// Symmetric FIR filter with programmable coefficients: one signed 16-bit
// sample in and one filtered sample out per item, one item per clock cycle
// when the output side keeps up. Registers follow the tap multipliers,
// which all work in parallel, each level of the adder tree and the scaling
// and saturation. The whole pipeline holds while a result waits at the
// output. Coefficients reset to the low-pass defaults; write them only
// while no item is in flight.
// depends on sfir_pkg, sfir_tap_cell, sfir_add_tree

module symmetric_fir_15_tap_q17_top
    import sfir_pkg::*;
#(
    parameter int TAPS = TAPS_DEF,
    parameter int SCALE_SHIFT = SCALE_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_sample              i_sample_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_sample              o_sample_out
);

    localparam t_acc ROUND_BIAS = ACC_W'((64'd1 << SCALE_SHIFT) - 64'd1);

    t_coef   r_coef [NUM_COEF];
    t_sample w_tap [TAPS+1];
    t_prod   w_prod [TAPS];
    logic    w_adv;
    logic    w_accept;
    logic    r_prod_vld;
    logic    w_sum_vld;
    t_acc    w_sum;
    t_acc    w_quot;
    t_sample n_sample_out;
    t_sample r_sample_out;
    logic    r_out_valid;

    assign w_adv = !r_out_valid || i_out_ready;
    assign w_accept = i_in_valid && w_adv;
    assign o_in_ready = w_adv;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= COEF_RESET[i];
            end
        end else if (i_cfg_we && i_cfg_idx >= REG_COEF_OUTER_0
                     && i_cfg_idx <= REG_COEF_CENTER) begin
            r_coef[i_cfg_idx[COEF_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // delay line of tap cells
    assign w_tap[0] = i_sample_in;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        localparam int CI = coef_index(k, TAPS);
        sfir_tap_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift_en (w_accept),
            .i_sample   (w_tap[k]),
            .i_coef     (r_coef[CI]),
            .o_sample   (w_tap[k+1]),
            .o_prod     (w_prod[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (w_adv) begin
            r_prod_vld <= w_accept;
        end
    end

    sfir_add_tree #(
        .TAPS (TAPS)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_prod_vld),
        .i_prod  (w_prod),
        .o_valid (w_sum_vld),
        .o_sum   (w_sum)
    );

    // divide toward zero, then saturate
    always_comb begin
        w_quot = (w_sum + (w_sum[ACC_W-1] ? ROUND_BIAS : t_acc'(0))) >>> SCALE_SHIFT;
        if (w_quot > ACC_W'(SAT_MAX)) begin
            n_sample_out = SAT_MAX;
        end else if (w_quot < ACC_W'(SAT_MIN)) begin
            n_sample_out = SAT_MIN;
        end else begin
            n_sample_out = w_quot[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sample_out <= n_sample_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

### dv/symmetric_fir_15_tap_q17_top_test.sv
// testbench for symmetric_fir_15_tap_q17_top: directed and random samples under
// random coefficient sets, with output predicted by an in-bench filter model
// depends on sfir_pkg and symmetric_fir_15_tap_q17_top

`timescale 1ns / 1ps

class fir_output_checker;
    sfir_pkg::t_coef coef_regs[sfir_pkg::NUM_COEF];
    sfir_pkg::t_sample past_samples[sfir_pkg::TAPS_DEF - 1];
    sfir_pkg::t_sample expected_outputs[$];
    int mismatches;

    function new();
        for (int i = 0; i < sfir_pkg::NUM_COEF; i++) coef_regs[i] = sfir_pkg::COEF_RESET[i];
        for (int i = 0; i < sfir_pkg::TAPS_DEF - 1; i++) past_samples[i] = '0;
        mismatches = 0;
    endfunction

    function void write_coef(logic [sfir_pkg::CFG_IDX_W-1:0] idx,
                             logic [sfir_pkg::COEF_W-1:0] data);
        if (idx < sfir_pkg::NUM_COEF) coef_regs[idx] = sfir_pkg::t_coef'(data);
    endfunction

    // filter one sample and queue the output it must produce
    function void take_sample(sfir_pkg::t_sample x);
        longint acc;
        longint quot;
        int m;
        sfir_pkg::t_sample tap_val;
        acc = 0;
        for (int k = 0; k < sfir_pkg::TAPS_DEF; k++) begin
            m = (k < sfir_pkg::TAPS_DEF - 1 - k) ? k : sfir_pkg::TAPS_DEF - 1 - k;
            tap_val = (k == 0) ? x : past_samples[k - 1];
            acc += longint'(coef_regs[m]) * longint'(tap_val);
        end
        // signed division truncates toward zero
        quot = acc / (longint'(1) << sfir_pkg::SCALE_SHIFT_DEF);
        if (quot > longint'(sfir_pkg::SAT_MAX)) quot = sfir_pkg::SAT_MAX;
        if (quot < longint'(sfir_pkg::SAT_MIN)) quot = sfir_pkg::SAT_MIN;
        for (int i = sfir_pkg::TAPS_DEF - 2; i > 0; i--) past_samples[i] = past_samples[i - 1];
        past_samples[0] = x;
        expected_outputs.push_back(sfir_pkg::t_sample'(quot));
    endfunction

    function void check_output(sfir_pkg::t_sample y);
        sfir_pkg::t_sample exp_y;
        if (expected_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: sample_out %0d", y);
        end else begin
            exp_y = expected_outputs.pop_front();
            if (y !== exp_y) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("sample_out mismatch: expected %0d, got %0d", exp_y, y);
                end
            end
        end
    endfunction

    function int pending();
        return expected_outputs.size();
    endfunction
endclass

module symmetric_fir_15_tap_q17_top_test;
    import sfir_pkg::*;

    typedef enum int {COEFS_DEFAULT, COEFS_RANDOM, COEFS_EXTREME, COEFS_SMALL} coef_style_e;

    localparam int LATENCY = $clog2(TAPS_DEF) + 2;
    localparam int RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 204;
    localparam int LONG_HOLD = 80;
    localparam int DRAIN_LIMIT = 5000;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(NUM_COEF);
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    t_sample i_sample_in;
    logic o_out_valid;
    logic i_out_ready;
    t_sample o_sample_out;

    fir_output_checker sb = new();
    t_sample last_sample = '0;
    bit tx_steady = 1'b1;
    bit rx_steady = 1'b1;
    bit rx_long_req = 1'b0;

    symmetric_fir_15_tap_q17_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sample_in(i_sample_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_sample_out(o_sample_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && o_in_ready === 1'b1) sb.take_sample(i_sample_in);
            if (o_out_valid === 1'b1 && i_out_ready) sb.check_output(o_sample_out);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_sample rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return t_sample'($urandom);
        if (r < 60) begin
            case ($urandom_range(0, 4))
                0: return SAT_MAX;
                1: return SAT_MIN;
                2: return t_sample'(0);
                3: return t_sample'(1);
                default: return t_sample'(-1);
            endcase
        end
        if (r < 75) return t_sample'(int'($urandom_range(0, 255)) - 128);
        if (r < 90) return last_sample;
        if ($urandom_range(0, 1)) return SAT_MAX - t_sample'($urandom_range(0, 15));
        return SAT_MIN + t_sample'($urandom_range(0, 15));
    endfunction

    function automatic t_coef pick_coef(coef_style_e style, int i);
        case (style)
            COEFS_DEFAULT: return COEF_RESET[i];
            COEFS_RANDOM: return t_coef'($urandom);
            COEFS_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return t_coef'(16'sh7fff);
                    1: return t_coef'(-16'sh8000);
                    2: return t_coef'(0);
                    3: return t_coef'(1);
                    default: return t_coef'(-1);
                endcase
            end
            default: return t_coef'(int'($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(t_sample x, int gap);
        i_in_valid = 1'b1;
        i_sample_in = x;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        last_sample = x;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        sb.write_coef(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(t_coef value);
        for (int i = 0; i < NUM_COEF; i++) write_reg(REG_COEF_OUTER_0 + CFG_IDX_W'(i), value);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int hold;
        hold = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_long_req) begin
                rx_long_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                i_out_ready = 1'b0;
                hold--;
            end else if (rx_steady || $urandom_range(0, 99) < 65) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = 1'b0;
                hold = pick_gap();
            end
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_sample dir_a [9];
        int waited;
        dir_a = '{SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, t_sample'(0), t_sample'(1),
                  t_sample'(-1), t_sample'(16'sh5555), t_sample'(16'shaaaa)};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_sample_in = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset coefficients, field extremes
        foreach (dir_a[i]) send_sample(dir_a[i], 0);

        // truncation toward zero on tiny negative sums; writes past the last register
        wait_drained();
        write_all(t_coef'(0));
        write_reg(REG_COEF_OUTER_0, COEF_W'(-1));
        for (logic [CFG_IDX_W:0] idx = REG_FIRST_UNUSED; idx <= REG_LAST_UNUSED; idx++) begin
            write_reg(idx[CFG_IDX_W-1:0], COEF_W'($urandom));
        end
        send_sample(t_sample'(1), 0);
        send_sample(SAT_MAX, 0);
        send_sample(SAT_MIN, 0);

        // negative saturation
        wait_drained();
        write_all(t_coef'(16'sh7fff));
        repeat (5) send_sample(SAT_MIN, 0);
        send_sample(SAT_MAX, 0);

        // positive saturation
        wait_drained();
        write_all(t_coef'(-16'sh8000));
        repeat (5) send_sample(SAT_MIN, 0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            for (int i = 0; i < NUM_COEF; i++) begin
                write_reg(REG_COEF_OUTER_0 + CFG_IDX_W'(i),
                          pick_coef(p < 4 ? coef_style_e'(p)
                                          : coef_style_e'($urandom_range(0, 3)), i));
            end
            tx_steady = (p == 1) || ($urandom_range(0, 3) == 0);
            rx_steady = (p != 1) && ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 1 && n == 20) rx_long_req = 1'b1;
                if (p == 3 && n == ITEMS_PER_PHASE / 2) wait_drained();
                send_sample(rand_sample(), tx_steady ? 0 : pick_gap());
            end
        end

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### symmetric_fir_15_tap_q17_top.f
rtl/sfir_pkg.sv
rtl/sfir_tap_cell.sv
rtl/sfir_add_tree.sv
rtl/symmetric_fir_15_tap_q17_top.sv
dv/symmetric_fir_15_tap_q17_top_test.sv
